@@ rtl/core/tsa_pkg.sv @@
// Package: constants, types and helpers shared by the slot allocator modules.
package tsa_pkg;

    localparam int PRIMARY_SLOTS = 8;
    localparam int QUEUE_SLOTS   = 8;
    localparam int COORD_BITS    = 16;
    localparam int ID_BITS       = 16;
    localparam int TIER_DEPTH    = 16;
    localparam int NUM_CELLS     = PRIMARY_SLOTS + QUEUE_SLOTS;
    localparam int CELL_IDX_BITS = $clog2(NUM_CELLS + 1);
    localparam int SLOT_SEL_BITS = $clog2(NUM_CELLS);
    localparam int DIST_BITS     = 2 * COORD_BITS + 1;
    localparam int IN_BITS       = 3 + 1 + 4 + 16 + 16 + 16;
    localparam int IN_BYTES_BITS = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS      = 1 + 1 + 4 + 16 + 16;
    localparam int OUT_BYTES_BITS = ((OUT_BITS + 7) / 8) * 8;

    typedef logic [2:0] cmd_t;
    localparam cmd_t CMD_LOAD    = 3'd0;
    localparam cmd_t CMD_FINISH  = 3'd1;
    localparam cmd_t CMD_RESERVE = 3'd2;
    localparam cmd_t CMD_PROMOTE = 3'd3;
    localparam cmd_t CMD_RELEASE = 3'd4;
    localparam cmd_t CMD_REL_ENT = 3'd5;
    localparam cmd_t CMD_READ    = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FREE,
        ST_SCAN,
        ST_DECIDE,
        ST_OUT
    } state_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic                  wr_pos;     // load position, free slot
        logic                  free_ent;   // free slots owned by id
        logic                  claim;      // mark taken, set owner
        logic                  unclaim;    // free this slot
        logic [SLOT_SEL_BITS-1:0] sel;     // addressed cell
        logic [ID_BITS-1:0]    id;
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
    } cell_ctl_t;

    // Running best-candidate token handed from cell to cell.
    typedef struct packed {
        logic                  found;
        logic [SLOT_SEL_BITS-1:0] idx;
        logic [DIST_BITS-1:0]  dist_sq;
    } scan_tok_t;

    function automatic logic [COORD_BITS-1:0] abs_diff(
        input logic [COORD_BITS-1:0] a, input logic [COORD_BITS-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

@@ rtl/core/two_tier_nearest_slot_allocator.sv @@
// Top level of the two-tier nearest slot allocator.
// The block holds a primary and a queue tier of slots as a row of cells;
// cells 0..PRIMARY_SLOTS-1 are the primary tier, the rest the queue tier.
// One command enters as a beat on the s_ channel; exactly one result beat
// leaves on the m_ channel. Commands are processed one at a time.
// Load, finish, release, release-entity, read and a reserve or promote that
// fails its checks go from ST_FREE straight to ST_OUT, which raises m_tvalid
// on the registered result. A searching reserve or promote passes a best-candidate
// token along the whole chain of cells, one cell per cycle; ST_DECIDE then
// claims the winner, if any. A reserve that finds no free primary slot
// makes a second pass for the queue tier.
// After reset no slot is taken and the table is not ready; every command
// but load and finish fails until finish has been given.
// The result is held in an output register; while the receiver stalls
// the result stays on m_tdata and no new command is accepted.
module two_tier_nearest_slot_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[2:0], tier[3], slot_index[7:4], entity_id[23:8],
    // pos_x[39:24], pos_y[55:40]
    input  logic [tsa_pkg::IN_BYTES_BITS-1:0]  s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[0], granted_tier[1], granted_index[5:2], read_x[21:6], read_y[37:22]
    output logic [tsa_pkg::OUT_BYTES_BITS-1:0] m_tdata
);
    import tsa_pkg::*;

    state_t state_reg, state_next;
    logic   tbl_ready_reg;
    cmd_t   cmd_reg;
    logic   tier_reg;
    logic [3:0] idx_reg;
    logic [ID_BITS-1:0]    id_reg;
    logic [COORD_BITS-1:0] px_reg, py_reg;
    logic   pass_reg;          // 0 first tier searched, 1 queue fallback
    logic [CELL_IDX_BITS-1:0] cnt_reg;
    logic   out_v_reg;
    logic [OUT_BYTES_BITS-1:0] out_reg;
    // Promote frees the queue slot the cycle after the primary claim.
    logic   unclaim_q_reg;

    cell_ctl_t ctl;
    scan_tok_t tok [NUM_CELLS+1];
    logic [NUM_CELLS-1:0] taken_v;
    logic [ID_BITS-1:0]    own_v [NUM_CELLS];
    logic [COORD_BITS-1:0] x_v [NUM_CELLS];
    logic [COORD_BITS-1:0] y_v [NUM_CELLS];
    logic scan_en;
    logic scan_tier;

    logic accept;
    logic valid_idx;
    logic [SLOT_SEL_BITS-1:0] cell_sel;
    logic [SLOT_SEL_BITS-1:0] q_cell;
    scan_tok_t res_tok;

    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE) && !out_v_reg;

    assign valid_idx = tier_reg ? (idx_reg < QUEUE_SLOTS) : (idx_reg < PRIMARY_SLOTS);
    assign cell_sel  = tier_reg ? SLOT_SEL_BITS'(PRIMARY_SLOTS + idx_reg)
                                : SLOT_SEL_BITS'(idx_reg);
    assign q_cell    = SLOT_SEL_BITS'(PRIMARY_SLOTS + idx_reg);
    assign res_tok   = tok[NUM_CELLS];

    // Token enters empty at cell 0 and is shifted one cell per cycle.
    assign tok[0] = '0;
    assign scan_en = (state_reg == ST_SCAN);
    assign scan_tier = (cmd_reg == CMD_RESERVE) ? pass_reg : 1'b0;

    genvar g;
    generate
        for (g = 0; g < NUM_CELLS; g++) begin : g_cell
            tsa_cell u_cell (
                .aclk(aclk), .aresetn(aresetn), .ctl(ctl),
                .my_idx(SLOT_SEL_BITS'(g)), .scan_en(scan_en),
                .scan_tier(scan_tier), .my_tier(g >= PRIMARY_SLOTS),
                .tok_in(tok[g]), .tok_out(tok[g+1]),
                .taken(taken_v[g]), .owner(own_v[g]),
                .pos_x(x_v[g]), .pos_y(y_v[g])
            );
        end
    endgenerate

    // Search point: the request point for reserve, the queue slot for promote.
    logic [COORD_BITS-1:0] sx, sy;
    assign sx = (cmd_reg == CMD_PROMOTE) ? x_v[q_cell] : px_reg;
    assign sy = (cmd_reg == CMD_PROMOTE) ? y_v[q_cell] : py_reg;

    logic promote_ok;
    assign promote_ok = tbl_ready_reg && idx_reg < QUEUE_SLOTS && taken_v[q_cell]
                        && own_v[q_cell] == id_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_FREE;
            ST_FREE: begin
                if (cmd_reg == CMD_RESERVE && tbl_ready_reg)
                    state_next = ST_SCAN;
                else if (cmd_reg == CMD_PROMOTE && promote_ok)
                    state_next = ST_SCAN;
                else
                    state_next = ST_OUT;
            end
            ST_SCAN: if (cnt_reg == CELL_IDX_BITS'(NUM_CELLS)) state_next = ST_DECIDE;
            ST_DECIDE: begin
                if (!res_tok.found && cmd_reg == CMD_RESERVE && !pass_reg)
                    state_next = ST_SCAN;
                else
                    state_next = ST_OUT;
            end
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Cell controls and result.
    logic [OUT_BYTES_BITS-1:0] out_next;
    logic st_ok;
    always_comb begin
        ctl = '0;
        ctl.id = id_reg;
        ctl.px = (state_reg == ST_FREE) ? px_reg : sx;
        ctl.py = (state_reg == ST_FREE) ? py_reg : sy;
        ctl.sel = cell_sel;
        out_next = out_reg;
        st_ok = 1'b0;
        case (state_reg)
            ST_FREE: begin
                out_next = '0;
                out_next[0] = 1'b1;
                case (cmd_reg)
                    CMD_LOAD: if (valid_idx) begin
                        ctl.wr_pos = 1'b1;
                        out_next[0] = 1'b0;
                    end
                    CMD_FINISH: out_next[0] = 1'b0;
                    CMD_RESERVE: ctl.free_ent = tbl_ready_reg;
                    CMD_RELEASE: if (tbl_ready_reg && valid_idx && taken_v[cell_sel]
                                     && own_v[cell_sel] == id_reg) begin
                        ctl.unclaim = 1'b1;
                        out_next[0] = 1'b0;
                    end
                    CMD_REL_ENT: if (tbl_ready_reg) begin
                        ctl.free_ent = 1'b1;
                        out_next[0] = 1'b0;
                    end
                    CMD_READ: if (tbl_ready_reg && valid_idx) begin
                        out_next[0] = 1'b0;
                        out_next[21:6]  = 16'(x_v[cell_sel]);
                        out_next[37:22] = 16'(y_v[cell_sel]);
                    end
                    default: ;
                endcase
            end
            ST_DECIDE: begin
                if (res_tok.found) begin
                    st_ok = 1'b1;
                    ctl.claim = 1'b1;
                    ctl.sel = res_tok.idx;
                    out_next[0] = 1'b0;
                    if (cmd_reg == CMD_RESERVE && pass_reg) begin
                        out_next[1] = 1'b1;
                        out_next[5:2] = 4'(res_tok.idx - SLOT_SEL_BITS'(PRIMARY_SLOTS));
                    end else begin
                        out_next[5:2] = 4'(res_tok.idx);
                    end
                end
            end
            default: ;
        endcase
        // The promoted queue slot is freed through the cell unclaim path.
        if (unclaim_q_reg) begin
            ctl.unclaim = 1'b1;
            ctl.sel = q_cell;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            tbl_ready_reg <= 1'b0;
            out_v_reg <= 1'b0;
            cnt_reg <= '0;
            pass_reg <= 1'b0;
            unclaim_q_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            unclaim_q_reg <= st_ok && cmd_reg == CMD_PROMOTE;
            if (state_reg == ST_FREE && cmd_reg == CMD_FINISH) tbl_ready_reg <= 1'b1;
            if (state_reg == ST_SCAN) cnt_reg <= cnt_reg + CELL_IDX_BITS'(1);
            else cnt_reg <= '0;
            if (state_reg == ST_FREE) pass_reg <= 1'b0;
            else if (state_reg == ST_DECIDE) pass_reg <= 1'b1;
            if (state_reg == ST_OUT) out_v_reg <= 1'b1;
            else if (m_tready) out_v_reg <= 1'b0;
        end
        if (accept) begin
            cmd_reg  <= s_tdata[2:0];
            tier_reg <= s_tdata[3];
            idx_reg  <= s_tdata[7:4];
            id_reg   <= ID_BITS'(s_tdata[23:8]);
            px_reg   <= COORD_BITS'(s_tdata[39:24]);
            py_reg   <= COORD_BITS'(s_tdata[55:40]);
        end
        out_reg <= out_next;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;
endmodule

@@ rtl/core/tsa_cell.sv @@
// One slot cell: position, taken flag, owner, and one stage of the nearest search.
module tsa_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tsa_pkg::cell_ctl_t   ctl,
    input  logic [tsa_pkg::SLOT_SEL_BITS-1:0] my_idx,
    input  logic                 scan_en,
    input  logic                 scan_tier,   // tier searched this pass
    input  logic                 my_tier,
    input  tsa_pkg::scan_tok_t   tok_in,
    output tsa_pkg::scan_tok_t   tok_out,
    output logic                 taken,
    output logic [tsa_pkg::ID_BITS-1:0]    owner,
    output logic [tsa_pkg::COORD_BITS-1:0] pos_x,
    output logic [tsa_pkg::COORD_BITS-1:0] pos_y
);
    import tsa_pkg::*;

    logic [COORD_BITS-1:0] x_reg, y_reg;
    logic [ID_BITS-1:0]    owner_reg;
    logic                  taken_reg;
    scan_tok_t             tok_reg, tok_next;
    logic [COORD_BITS-1:0] dx, dy;
    logic [2*COORD_BITS-1:0] dx2, dy2;
    logic [DIST_BITS-1:0]  d;
    logic                  hit;

    assign hit = (ctl.sel == my_idx);
    assign dx  = abs_diff(x_reg, ctl.px);
    assign dy  = abs_diff(y_reg, ctl.py);
    assign dx2 = {COORD_BITS'(0), dx} * {COORD_BITS'(0), dx};
    assign dy2 = {COORD_BITS'(0), dy} * {COORD_BITS'(0), dy};
    assign d   = DIST_BITS'(dx2) + DIST_BITS'(dy2);

    always_comb begin
        tok_next = tok_in;
        if (scan_en && my_tier == scan_tier && !taken_reg &&
            (!tok_in.found || d < tok_in.dist_sq)) begin
            tok_next.found   = 1'b1;
            tok_next.idx     = my_idx;
            tok_next.dist_sq = d;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            taken_reg <= 1'b0;
        end else if (ctl.wr_pos && hit) begin
            taken_reg <= 1'b0;
        end else if (ctl.claim && hit) begin
            taken_reg <= 1'b1;
        end else if (ctl.unclaim && hit) begin
            taken_reg <= 1'b0;
        end else if (ctl.free_ent && taken_reg && owner_reg == ctl.id) begin
            taken_reg <= 1'b0;
        end
        if (ctl.wr_pos && hit) begin
            x_reg <= ctl.px;
            y_reg <= ctl.py;
        end
        if (ctl.claim && hit) begin
            owner_reg <= ctl.id;
        end
        tok_reg <= tok_next;
    end

    assign tok_out = tok_reg;
    assign taken   = taken_reg;
    assign owner   = owner_reg;
    assign pos_x   = x_reg;
    assign pos_y   = y_reg;
endmodule

@@ tb/sv/two_tier_nearest_slot_allocator_tb.sv @@
// Self-checking testbench for the two-tier nearest slot allocator.
module two_tier_nearest_slot_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tsa_pkg::*;

    // Command code with no meaning; it must fail and change nothing.
    localparam cmd_t CMD_UNUSED = 3'd7;

    // One expected or observed result beat.
    typedef struct packed {
        logic [15:0] read_y;
        logic [15:0] read_x;
        logic [3:0]  granted_index;
        logic        granted_tier;
        logic        status;
    } alloc_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_BYTES_BITS-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_BYTES_BITS-1:0] m_tdata;

    two_tier_nearest_slot_allocator DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Shadow copy of the slot table; index [tier][slot].
    logic [15:0] shadow_x [2][16];
    logic [15:0] shadow_y [2][16];
    logic        shadow_taken [2][16];
    logic [15:0] shadow_owner [2][16];
    logic        shadow_loaded [2][16];
    logic        shadow_ready;

    alloc_result_t pending_results [$];
    int  error_count = 0;
    bit  sender_bursts = 1'b1;
    bit  receiver_bursts = 1'b1;
    int  hold_off_cycles = 0;

    function automatic int tier_slots(input int t);
        return t ? QUEUE_SLOTS : PRIMARY_SLOTS;
    endfunction

    // Nearest free slot of a tier to a point, lowest index winning ties; -1 when full.
    function automatic int find_nearest(input int t, input logic [15:0] px,
                                        input logic [15:0] py);
        int best;
        longint unsigned best_d, d, dx, dy;
        best = -1;
        best_d = 0;
        for (int i = 0; i < tier_slots(t); i++) begin
            if (!shadow_taken[t][i]) begin
                dx = (shadow_x[t][i] > px) ? shadow_x[t][i] - px : px - shadow_x[t][i];
                dy = (shadow_y[t][i] > py) ? shadow_y[t][i] - py : py - shadow_y[t][i];
                d = dx * dx + dy * dy;
                if (best < 0 || d < best_d) begin
                    best = i;
                    best_d = d;
                end
            end
        end
        return best;
    endfunction

    function automatic void drop_claims(input logic [15:0] id);
        for (int t = 0; t < 2; t++)
            for (int i = 0; i < tier_slots(t); i++)
                if (shadow_taken[t][i] && shadow_owner[t][i] == id)
                    shadow_taken[t][i] = 1'b0;
    endfunction

    // Applies one command to the shadow table and returns the result it should produce.
    function automatic alloc_result_t allocate_step(input cmd_t cmd, input int tier,
            input int idx, input logic [15:0] id, input logic [15:0] px,
            input logic [15:0] py);
        alloc_result_t r;
        bit ok;
        int k;
        r = '0;
        r.status = 1'b1;
        ok = idx < tier_slots(tier);
        case (cmd)
            CMD_LOAD: begin
                if (ok) begin
                    shadow_x[tier][idx] = px;
                    shadow_y[tier][idx] = py;
                    shadow_taken[tier][idx] = 1'b0;
                    shadow_loaded[tier][idx] = 1'b1;
                    r.status = 1'b0;
                end
            end
            CMD_FINISH: begin
                shadow_ready = 1'b1;
                r.status = 1'b0;
            end
            CMD_RESERVE: begin
                if (shadow_ready) begin
                    drop_claims(id);
                    for (int t = 0; t < 2; t++) begin
                        k = find_nearest(t, px, py);
                        if (k >= 0 && r.status) begin
                            shadow_taken[t][k] = 1'b1;
                            shadow_owner[t][k] = id;
                            r.status = 1'b0;
                            r.granted_tier = t[0];
                            r.granted_index = k[3:0];
                        end
                    end
                end
            end
            CMD_PROMOTE: begin
                if (shadow_ready && idx < QUEUE_SLOTS && shadow_taken[1][idx] &&
                    shadow_owner[1][idx] == id) begin
                    k = find_nearest(0, shadow_x[1][idx], shadow_y[1][idx]);
                    if (k >= 0) begin
                        shadow_taken[0][k] = 1'b1;
                        shadow_owner[0][k] = id;
                        shadow_taken[1][idx] = 1'b0;
                        r.status = 1'b0;
                        r.granted_index = k[3:0];
                    end
                end
            end
            CMD_RELEASE: begin
                if (shadow_ready && ok && shadow_taken[tier][idx] &&
                    shadow_owner[tier][idx] == id) begin
                    shadow_taken[tier][idx] = 1'b0;
                    r.status = 1'b0;
                end
            end
            CMD_REL_ENT: begin
                if (shadow_ready) begin
                    drop_claims(id);
                    r.status = 1'b0;
                end
            end
            CMD_READ: begin
                if (shadow_ready && ok) begin
                    r.status = 1'b0;
                    r.read_x = shadow_x[tier][idx];
                    r.read_y = shadow_y[tier][idx];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Sends one command beat, predicting its result at acceptance.
    // tvalid stays high after the beat; idling or wait_drained lowers it.
    task automatic send_command(input cmd_t cmd, input int tier, input int idx,
            input logic [15:0] id, input logic [15:0] px, input logic [15:0] py);
        logic [IN_BYTES_BITS-1:0] beat;
        if (sender_bursts && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        beat = '0;
        beat[2:0] = cmd;
        beat[3] = tier[0];
        beat[7:4] = idx[3:0];
        beat[23:8] = id;
        beat[39:24] = px;
        beat[55:40] = py;
        s_tdata <= beat;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(allocate_step(cmd, tier, idx, id, px, py));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Receiver: random stall bursts, plus one long hold-off when asked.
    initial begin
        m_tready <= 1'b0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (hold_off_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (hold_off_cycles) @(posedge aclk);
                hold_off_cycles = 0;
            end else if (receiver_bursts && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3) - 1) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Result checker: compares every accepted result beat with the oldest prediction.
    initial begin
        alloc_result_t got, want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got = m_tdata[37:0];
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, got);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, got.status);
                        error_count++;
                    end
                    if (got.granted_tier !== want.granted_tier) begin
                        $display("%0t: granted_tier expected %0d actual %0d", $time,
                                 want.granted_tier, got.granted_tier);
                        error_count++;
                    end
                    if (got.granted_index !== want.granted_index) begin
                        $display("%0t: granted_index expected %0d actual %0d", $time,
                                 want.granted_index, got.granted_index);
                        error_count++;
                    end
                    if (got.read_x !== want.read_x) begin
                        $display("%0t: read_x expected %h actual %h", $time,
                                 want.read_x, got.read_x);
                        error_count++;
                    end
                    if (got.read_y !== want.read_y) begin
                        $display("%0t: read_y expected %h actual %h", $time,
                                 want.read_y, got.read_y);
                        error_count++;
                    end
                end
            end
        end
    end

    // Commands before finish must fail; an out-of-range load fails too.
    task automatic test_not_ready();
        send_command(CMD_RESERVE, 0, 0, 16'h0001, 16'h0000, 16'h0000);
        send_command(CMD_PROMOTE, 1, 0, 16'h0001, 16'h0000, 16'h0000);
        send_command(CMD_RELEASE, 0, 0, 16'h0001, 16'h0000, 16'h0000);
        send_command(CMD_REL_ENT, 0, 0, 16'h0001, 16'h0000, 16'h0000);
        send_command(CMD_READ, 0, 0, 16'h0001, 16'h0000, 16'h0000);
        send_command(CMD_LOAD, 0, 15, 16'h0001, 16'hFFFF, 16'hFFFF);
        send_command(CMD_UNUSED, 1, 15, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    endtask

    // Loads every slot, with the coordinate extremes present, then finishes twice.
    task automatic test_build_table();
        for (int t = 0; t < 2; t++)
            for (int i = 0; i < tier_slots(t); i++)
                send_command(CMD_LOAD, t, i, 16'(i), (i == 0) ? 16'h0000 :
                             (i == 1) ? 16'hFFFF : 16'($urandom),
                             (i == 0) ? 16'hFFFF : (i == 1) ? 16'h0000 : 16'($urandom));
        send_command(CMD_FINISH, 0, 0, 16'h0000, 16'h0000, 16'h0000);
        send_command(CMD_FINISH, 1, 15, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    endtask

    // Fills the primary tier, overflows into the queue, then promotes and releases.
    task automatic test_directed_claims();
        for (int e = 1; e <= PRIMARY_SLOTS + 1; e++)
            send_command(CMD_RESERVE, 1, 15, 16'(e), 16'h8000, 16'h8000);
        send_command(CMD_READ, 1, 15, 16'h0000, 16'h0000, 16'h0000);
        send_command(CMD_READ, 1, 7, 16'hFFFF, 16'h0000, 16'h0000);
        send_command(CMD_PROMOTE, 1, 15, 16'(PRIMARY_SLOTS + 1), 16'h0000, 16'h0000);
        send_command(CMD_RELEASE, 0, 0, 16'hFFFF, 16'h0000, 16'h0000);
        send_command(CMD_REL_ENT, 0, 0, 16'h0001, 16'h0000, 16'h0000);
        send_command(CMD_REL_ENT, 0, 0, 16'h0002, 16'h0000, 16'h0000);
        for (int q = 0; q < QUEUE_SLOTS; q++)
            send_command(CMD_PROMOTE, 0, q, 16'(PRIMARY_SLOTS + 1), 16'h0000, 16'h0000);
        send_command(CMD_LOAD, 0, 3, 16'h0000, 16'h1234, 16'h4321);
        wait_drained();
    endtask

    // Random traffic biased towards claims by a small set of entities.
    task automatic test_random_traffic(input int count);
        cmd_t cmd;
        int tier, idx, pick;
        logic [15:0] id;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            cmd = (pick < 35) ? CMD_RESERVE : (pick < 50) ? CMD_PROMOTE :
                  (pick < 65) ? CMD_RELEASE : (pick < 72) ? CMD_REL_ENT :
                  (pick < 85) ? CMD_READ : (pick < 93) ? CMD_LOAD :
                  (pick < 96) ? CMD_FINISH : CMD_UNUSED;
            tier = $urandom_range(0, 1);
            // Mostly valid indices; sometimes out of range to exercise failures.
            idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                              : $urandom_range(0, tier_slots(tier) - 1);
            id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 11));
            // Never read a position that was never written.
            if (!shadow_loaded[tier][idx] && cmd == CMD_READ) cmd = CMD_LOAD;
            send_command(cmd, tier, idx, id, 16'($urandom), 16'($urandom));
        end
    endtask

    // Receiver holds off for a long stretch whilst the sender keeps offering beats.
    task automatic test_back_pressure();
        hold_off_cycles = 200;
        test_random_traffic(40);
        wait_drained();
    endtask

    initial begin
        for (int t = 0; t < 2; t++)
            for (int i = 0; i < 16; i++) begin
                shadow_taken[t][i] = 1'b0;
                shadow_loaded[t][i] = 1'b0;
                shadow_x[t][i] = '0;
                shadow_y[t][i] = '0;
                shadow_owner[t][i] = '0;
            end
        shadow_ready = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_not_ready();
        test_build_table();
        test_directed_claims();
        test_random_traffic(1000);
        test_back_pressure();
        test_random_traffic(300);
        // Final stretch without any idling on either side.
        sender_bursts = 1'b0;
        receiver_bursts = 1'b0;
        test_random_traffic(200);
        wait_drained();
        repeat (40) @(posedge aclk);
        if (error_count == 0)
            $display("two_tier_nearest_slot_allocator_tb: done, clean");
        else
            $display("two_tier_nearest_slot_allocator_tb: done, errors");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5ms;
        $display("two_tier_nearest_slot_allocator_tb: done, errors");
        $finish;
    end

endmodule
